### hdl/c3f_pkg.sv
// Shared constants and controller/datapath interface types for the 3x3 RGB filter.
`timescale 1ns / 1ps
package c3f_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_HEIGHT     = 2048;
  localparam int ADDR_BITS      = $clog2(MAX_WIDTH);
  localparam int POS_BITS       = 11;
  localparam int DIM_BITS       = 12;
  localparam int PIX_BITS       = 8;
  localparam int NUM_CH         = 3;
  localparam int RGB_BITS       = NUM_CH * PIX_BITS;
  localparam int COEF_BITS      = 12;
  localparam int COEF_FRAC_BITS = 8;
  localparam int KROW_BITS      = 3 * COEF_BITS;
  localparam int NORM_BITS      = 8;
  localparam int NUM_TAPS       = 9;
  localparam int TAP_BITS       = 4;
  localparam int PROD_BITS      = PIX_BITS + 1 + COEF_BITS;
  localparam int ACC_BITS       = 25;
  localparam int QUO_BITS       = ACC_BITS - COEF_FRAC_BITS;
  localparam int STEP_BITS      = $clog2(QUO_BITS);
  localparam int OFFSET_127     = 127;
  localparam int CFG_IDX_BITS   = 3;
  localparam int OUT_BITS       = 48;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_BOTTOM = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NORMALISER    = 3'd5;

  localparam logic [DIM_BITS-1:0]  RST_WIDTH  = 12'd640;
  localparam logic [DIM_BITS-1:0]  RST_HEIGHT = 12'd480;
  localparam logic [KROW_BITS-1:0] RST_KROW   = 36'h100100100;
  localparam logic [NORM_BITS-1:0] RST_NORM   = 8'd9;

  typedef struct packed {
    logic                accept;
    logic                mem_rd;
    logic                shift;
    logic                mac;
    logic [TAP_BITS-1:0] tap;
    logic                div_init;
    logic                div_step;
    logic                out_load;
  } c3f_cmd_t;

  typedef struct packed {
    logic interior;
    logic out_free;
  } c3f_sts_t;

endpackage

### hdl/c3f_datapath.sv
// Datapath: config registers, position counters, line stores, window, MAC and divider.
`timescale 1ns / 1ps
module c3f_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  c3f_pkg::c3f_cmd_t                    cmd_i,
  output c3f_pkg::c3f_sts_t                    sts_o,
  input  logic                                 cfg_valid_i,
  input  logic [c3f_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [c3f_pkg::KROW_BITS-1:0]        cfg_data_i,
  input  logic [c3f_pkg::RGB_BITS-1:0]         pix_i,
  input  logic                                 sof_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [c3f_pkg::OUT_BITS-1:0]         out_data_o,
  output logic                                 out_last_o
);
  import c3f_pkg::*;

  logic [DIM_BITS-1:0]         width_q, height_q;
  logic [KROW_BITS-1:0]        ktop_q, kmid_q, kbot_q;
  logic signed [NORM_BITS-1:0] norm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      ktop_q   <= RST_KROW;
      kmid_q   <= RST_KROW;
      kbot_q   <= RST_KROW;
      norm_q   <= RST_NORM;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:   width_q  <= cfg_data_i[DIM_BITS-1:0];
        CFG_IMAGE_HEIGHT:  height_q <= cfg_data_i[DIM_BITS-1:0];
        CFG_KERNEL_TOP:    ktop_q   <= cfg_data_i;
        CFG_KERNEL_MIDDLE: kmid_q   <= cfg_data_i;
        CFG_KERNEL_BOTTOM: kbot_q   <= cfg_data_i;
        CFG_NORMALISER:    norm_q   <= cfg_data_i[NORM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Position tracking
  logic [POS_BITS-1:0] col_q, row_q, cur_c_q, cur_r_q;
  logic [DIM_BITS-1:0] wc, hc, pc, pr, nc, nr;
  logic                interior_q, last_q;
  logic [RGB_BITS-1:0] pix_q;

  always_comb begin
    wc = width_q;
    if (width_q < DIM_BITS'(3)) wc = DIM_BITS'(3);
    else if (width_q > DIM_BITS'(MAX_WIDTH)) wc = DIM_BITS'(MAX_WIDTH);
    hc = height_q;
    if (height_q < DIM_BITS'(3)) hc = DIM_BITS'(3);
    else if (height_q > DIM_BITS'(MAX_HEIGHT)) hc = DIM_BITS'(MAX_HEIGHT);
    if (sof_i) begin
      pc = '0;
      pr = '0;
    end else begin
      pc = {1'b0, col_q};
      pr = {1'b0, row_q};
      // wrap a position left beyond a lowered size
      if (pc >= wc) begin
        pc = '0;
        pr = pr + DIM_BITS'(1);
      end
      if (pr >= hc) pr = '0;
    end
    nc = pc + DIM_BITS'(1);
    nr = pr;
    if (nc >= wc) begin
      nc = '0;
      nr = pr + DIM_BITS'(1);
      if (nr >= hc) nr = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      col_q <= nc[POS_BITS-1:0];
      row_q <= nr[POS_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_c_q    <= pc[POS_BITS-1:0];
      cur_r_q    <= pr[POS_BITS-1:0];
      pix_q      <= pix_i;
      interior_q <= (pc >= DIM_BITS'(2)) && (pr >= DIM_BITS'(2));
      last_q     <= (pc == wc - DIM_BITS'(1)) && (pr == hc - DIM_BITS'(1));
    end
  end

  // Line stores: read one cycle, write back the next
  logic [RGB_BITS-1:0] upper_mem [MAX_WIDTH];
  logic [RGB_BITS-1:0] lower_mem [MAX_WIDTH];
  logic [RGB_BITS-1:0] top_q, mid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      top_q <= upper_mem[cur_c_q[ADDR_BITS-1:0]];
      mid_q <= lower_mem[cur_c_q[ADDR_BITS-1:0]];
    end
    if (cmd_i.shift) begin
      upper_mem[cur_c_q[ADDR_BITS-1:0]] <= mid_q;
      lower_mem[cur_c_q[ADDR_BITS-1:0]] <= pix_q;
    end
  end

  // 3x3 window
  logic [RGB_BITS-1:0] win_q [NUM_TAPS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      for (int k = 0; k < 3; k++) begin
        win_q[3*k]   <= win_q[3*k+1];
        win_q[3*k+1] <= win_q[3*k+2];
      end
      win_q[2] <= top_q;
      win_q[5] <= mid_q;
      win_q[8] <= pix_q;
    end
  end

  // One tap per cycle, all three channels in parallel
  logic signed [COEF_BITS-1:0] coef;
  logic [RGB_BITS-1:0]         wsel;

  always_comb begin
    case (cmd_i.tap)
      4'd0:    coef = ktop_q[3*COEF_BITS-1:2*COEF_BITS];
      4'd1:    coef = ktop_q[2*COEF_BITS-1:COEF_BITS];
      4'd2:    coef = ktop_q[COEF_BITS-1:0];
      4'd3:    coef = kmid_q[3*COEF_BITS-1:2*COEF_BITS];
      4'd4:    coef = kmid_q[2*COEF_BITS-1:COEF_BITS];
      4'd5:    coef = kmid_q[COEF_BITS-1:0];
      4'd6:    coef = kbot_q[3*COEF_BITS-1:2*COEF_BITS];
      4'd7:    coef = kbot_q[2*COEF_BITS-1:COEF_BITS];
      4'd8:    coef = kbot_q[COEF_BITS-1:0];
      default: coef = '0;
    endcase
    wsel = (cmd_i.tap < TAP_BITS'(NUM_TAPS)) ? win_q[cmd_i.tap] : '0;
  end

  logic signed [ACC_BITS-1:0]  acc_q  [NUM_CH];
  logic signed [PROD_BITS-1:0] prod   [NUM_CH];
  logic [QUO_BITS-1:0]         num_q  [NUM_CH];
  logic [NORM_BITS-1:0]        rem_q  [NUM_CH];
  logic                        neg_q  [NUM_CH];
  logic [NORM_BITS-1:0]        dvs_q;
  logic signed [ACC_BITS:0]    tsum   [NUM_CH];
  logic [ACC_BITS:0]           mag    [NUM_CH];
  logic [NORM_BITS-1:0]        trial  [NUM_CH];
  logic [NORM_BITS:0]          nabs;
  logic                        nzero;

  always_comb begin
    nzero = (norm_q == '0);
    nabs  = norm_q[NORM_BITS-1] ? (NORM_BITS+1)'(-{norm_q[NORM_BITS-1], norm_q})
                                : {1'b0, norm_q};
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch]  = $signed({1'b0, wsel[PIX_BITS*ch +: PIX_BITS]}) * coef;
      tsum[ch]  = (ACC_BITS+1)'(acc_q[ch]);
      if (nzero) tsum[ch] = tsum[ch] + (ACC_BITS+1)'(OFFSET_127 << COEF_FRAC_BITS);
      mag[ch]   = tsum[ch][ACC_BITS] ? (ACC_BITS+1)'(-tsum[ch]) : tsum[ch];
      trial[ch] = {rem_q[ch][NORM_BITS-2:0], num_q[ch][QUO_BITS-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) dvs_q <= nzero ? NORM_BITS'(1) : nabs[NORM_BITS-1:0];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (cmd_i.shift) begin
        acc_q[ch] <= '0;
      end else if (cmd_i.mac) begin
        acc_q[ch] <= acc_q[ch] + ACC_BITS'(prod[ch]);
      end
      if (cmd_i.div_init) begin
        num_q[ch] <= mag[ch][ACC_BITS-1:COEF_FRAC_BITS];
        rem_q[ch] <= '0;
        neg_q[ch] <= nzero ? tsum[ch][ACC_BITS] : (tsum[ch][ACC_BITS] ^ norm_q[NORM_BITS-1]);
      end else if (cmd_i.div_step) begin
        // restoring step: the quotient bit shifts in behind the numerator
        if (trial[ch] >= dvs_q) begin
          rem_q[ch] <= trial[ch] - dvs_q;
          num_q[ch] <= {num_q[ch][QUO_BITS-2:0], 1'b1};
        end else begin
          rem_q[ch] <= trial[ch];
          num_q[ch] <= {num_q[ch][QUO_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // Output register
  logic                 out_valid_q, out_last_q;
  logic [OUT_BITS-1:0]  out_data_q;
  logic [RGB_BITS-1:0]  res;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      res[PIX_BITS*ch +: PIX_BITS] = neg_q[ch] ? PIX_BITS'(-num_q[ch][PIX_BITS-1:0])
                                               : num_q[ch][PIX_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {2'b00, cur_r_q - POS_BITS'(1), cur_c_q - POS_BITS'(1), res};
      out_last_q <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign out_last_o      = out_last_q;
  assign sts_o.interior  = interior_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

### hdl/c3f_ctrl.sv
// Controller: sequences line-store access, window shift, kernel taps and divider steps.
`timescale 1ns / 1ps
module c3f_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  c3f_pkg::c3f_sts_t sts_i,
  output c3f_pkg::c3f_cmd_t cmd_o
);
  import c3f_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_SHIFT, ST_MAC, ST_LOAD, ST_DIV, ST_DONE
  } state_e;

  state_e               state_q;
  logic                 rdy_q;
  logic [TAP_BITS-1:0]  tap_q;
  logic [STEP_BITS-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rdy_q   <= 1'b1;
      tap_q   <= '0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && rdy_q) begin
            state_q <= ST_READ;
            rdy_q   <= 1'b0;
          end
        end
        ST_READ: state_q <= ST_SHIFT;
        ST_SHIFT: begin
          tap_q <= '0;
          if (sts_i.interior) begin
            state_q <= ST_MAC;
          end else begin
            state_q <= ST_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        ST_MAC: begin
          tap_q <= tap_q + TAP_BITS'(1);
          if (tap_q == TAP_BITS'(NUM_TAPS - 1)) state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + STEP_BITS'(1);
          if (step_q == STEP_BITS'(QUO_BITS - 1)) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o      = rdy_q;
  assign cmd_o.accept    = rdy_q && in_valid_i;
  assign cmd_o.mem_rd    = (state_q == ST_READ);
  assign cmd_o.shift     = (state_q == ST_SHIFT);
  assign cmd_o.mac       = (state_q == ST_MAC);
  assign cmd_o.tap       = tap_q;
  assign cmd_o.div_init  = (state_q == ST_LOAD);
  assign cmd_o.div_step  = (state_q == ST_DIV);
  assign cmd_o.out_load  = (state_q == ST_DONE) && sts_i.out_free;

  a_rdy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy_q |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MAC |-> tap_q < TAP_BITS'(NUM_TAPS)) else $error("tap out of range");
  a_load_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> state_q == ST_IDLE && rdy_q) else $error("no return after load");
  a_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && !sts_i.interior) |=> rdy_q) else $error("border stalled");

endmodule

### hdl/conv3x3_rgb_filter.sv
// Top level of the streaming 3x3 RGB convolution filter.
`timescale 1ns / 1ps
// Takes RGB pixels in raster order and returns one filtered pixel for each
// interior position of the frame; border pixels produce no output beat. A
// border pixel occupies the block for the line-store read, write-back and
// window shift; an interior pixel then runs the single-tap multiply-accumulate
// (nine kernel taps), the divider load and the bit-serial divider (17 quotient
// bits), then waits for a free output register. The next pixel beat is taken
// only after that, while the result may still wait in the output register.
module conv3x3_rgb_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [c3f_pkg::RGB_BITS-1:0]      s_axis_tdata,  // red, green, blue
  input  logic                              s_axis_tuser,  // start_of_frame
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // red_out, green_out, blue_out, out_column, out_row, zero pad
  output logic [c3f_pkg::OUT_BITS-1:0]      m_axis_tdata,
  output logic                              m_axis_tlast,  // last_of_frame
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [c3f_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [c3f_pkg::KROW_BITS-1:0]     cfg_data_i
);
  import c3f_pkg::*;

  c3f_cmd_t cmd;
  c3f_sts_t sts;

  assign cfg_ready_o = 1'b1;

  c3f_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  c3f_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (s_axis_tdata),
    .sof_i       (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### verif/tb_conv3x3_rgb_filter.sv
// Self-checking testbench for the streaming 3x3 RGB convolution filter.
`timescale 1ns / 1ps
module tb_conv3x3_rgb_filter;
  import c3f_pkg::*;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] col;
    logic [10:0] row;
    logic        last;
  } filt_px_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [RGB_BITS-1:0]     s_axis_tdata = '0;
  logic                    s_axis_tuser = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0]     m_axis_tdata;
  logic                    m_axis_tlast;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [KROW_BITS-1:0]    cfg_data_i = '0;

  conv3x3_rgb_filter dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state and register copy
  logic [11:0]       width_reg  = RST_WIDTH;
  logic [11:0]       height_reg = RST_HEIGHT;
  logic [35:0]       krow [3]   = '{RST_KROW, RST_KROW, RST_KROW};
  logic [7:0]        norm_reg   = RST_NORM;
  logic [23:0]       upper_line [MAX_WIDTH];
  logic [23:0]       lower_line [MAX_WIDTH];
  logic [23:0]       win [9];
  int                col_cnt = 0;
  int                row_cnt = 0;
  filt_px_t          filtered_q [$];

  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  logic              hold_rx = 1'b0;
  int                errors = 0;
  int                cycles = 0;

  function automatic logic [7:0] filter_byte(int ch);
    int acc, p, coef, n, q;
    acc = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p    = win[r*3+c][ch*8 +: 8];
        coef = $signed(krow[r][35-12*c -: 12]);
        acc += p * coef;
      end
    end
    n = $signed(norm_reg);
    if (n != 0) q = acc / (n * 256);
    else q = (acc + OFFSET_127 * 256) / 256;
    return q[7:0];
  endfunction

  task automatic convolve_pixel(input logic [23:0] pix, input logic sof);
    int w, h, c, r;
    logic [23:0] top, mid;
    filt_px_t e;
    w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    if (sof) begin
      col_cnt = 0;
      row_cnt = 0;
    end else begin
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= h) row_cnt = 0;
    end
    c = col_cnt;
    r = row_cnt;
    top = upper_line[c];
    mid = lower_line[c];
    upper_line[c] = mid;
    lower_line[c] = pix;
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = pix;
    if (c >= 2 && r >= 2) begin
      e.red   = filter_byte(0);
      e.green = filter_byte(1);
      e.blue  = filter_byte(2);
      e.col   = 11'(c - 1);
      e.row   = 11'(r - 1);
      e.last  = (c == w - 1) && (r == h - 1);
      filtered_q.push_back(e);
    end
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  task automatic send_pixel(input logic [23:0] pix, input logic sof);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= sof;
    do @(posedge clk_i); while (!s_axis_tready);
    convolve_pixel(pix, sof);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    // border pixels leave no result behind, so give them time to retire
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [35:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:   width_reg  = val[11:0];
      CFG_IMAGE_HEIGHT:  height_reg = val[11:0];
      CFG_KERNEL_TOP:    krow[0]    = val;
      CFG_KERNEL_MIDDLE: krow[1]    = val;
      CFG_KERNEL_BOTTOM: krow[2]    = val;
      CFG_NORMALISER:    norm_reg   = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_kernel(input logic [35:0] t, input logic [35:0] m,
                            input logic [35:0] b, input logic [7:0] n);
    write_reg(CFG_KERNEL_TOP, t);
    write_reg(CFG_KERNEL_MIDDLE, m);
    write_reg(CFG_KERNEL_BOTTOM, b);
    write_reg(CFG_NORMALISER, {28'd0, n});
  endtask

  task automatic send_frame(input int npix, input bit with_sof);
    for (int i = 0; i < npix; i++)
      send_pixel(24'($urandom), with_sof && i == 0);
  endtask

  task automatic test_directed();
    // out-of-range sizes clamp to the 3x3 minimum
    write_reg(CFG_IMAGE_WIDTH, 36'd0);
    write_reg(CFG_IMAGE_HEIGHT, 36'd0);
    for (int i = 0; i < 9; i++) send_pixel(24'hFFFFFF, i == 0);
    for (int i = 0; i < 9; i++) send_pixel(24'h000000, 1'b0);  // wraps without start
    set_kernel({3{12'h800}}, {3{12'h800}}, {3{12'h800}}, 8'h80);
    for (int i = 0; i < 9; i++) send_pixel(24'hFFFFFF, i == 0);
    set_kernel({3{12'h7FF}}, {3{12'h7FF}}, {3{12'h7FF}}, 8'h7F);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 24'hFF00FF : 24'h00FF00, i == 0);
    set_kernel(36'h000000000, 36'h000100000, 36'h000000000, 8'h00);
    for (int i = 0; i < 9; i++) send_pixel(24'($urandom), i == 0);
    set_kernel(36'h000000000, 36'h000F00000, 36'h000000000, 8'hFF);
    for (int i = 0; i < 9; i++) send_pixel(24'($urandom), i == 0);
  endtask

  task automatic test_large_sizes();
    send_idle_pct = 0;
    // oversized settings clamp; send the start of each frame only
    write_reg(CFG_IMAGE_WIDTH, 36'd4095);
    write_reg(CFG_IMAGE_HEIGHT, 36'd3);
    send_frame(60, 1'b1);
    write_reg(CFG_IMAGE_WIDTH, 36'd3);
    write_reg(CFG_IMAGE_HEIGHT, 36'd4095);
    send_frame(60, 1'b1);
    write_reg(CFG_IMAGE_WIDTH, 36'd8);
    write_reg(CFG_IMAGE_HEIGHT, 36'd6);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_IMAGE_WIDTH, 36'd8);
    write_reg(CFG_IMAGE_HEIGHT, 36'd6);
    fork
      begin
        hold_rx <= 1'b1;
        repeat (600) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
    join_none
    send_frame(48, 1'b1);
    // let the pipe drain completely, then resume
    wait_idle();
    send_frame(48, 1'b1);
  endtask

  task automatic test_random(input int target, input int s_pct, input int r_pct);
    int sent, w, h;
    logic [7:0] n;
    sent = 0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (sent < target) begin
      if ($urandom_range(9) == 0) begin
        // keep settings and carry on without a start marker
        send_frame(int'(width_reg) * int'(height_reg), 1'b0);
      end else begin
        w = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(3, 8);
        h = $urandom_range(3, 6);
        case ($urandom_range(5))
          0: n = 8'h00;
          1: n = 8'h01;
          2: n = 8'hFF;
          3: n = 8'h80;
          4: n = 8'h7F;
          default: n = 8'($urandom);
        endcase
        write_reg(CFG_IMAGE_WIDTH, 36'(w));
        write_reg(CFG_IMAGE_HEIGHT, 36'(h));
        set_kernel(36'({$urandom, $urandom}), 36'({$urandom, $urandom}),
                   36'({$urandom, $urandom}), n);
        for (int i = 0; i < w * h; i++)
          send_pixel(24'($urandom), i == 0 || $urandom_range(49) == 0);
      end
      sent += int'(width_reg) * int'(height_reg);
    end
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_conv3x3_rgb_filter: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, and check each result beat
  always @(posedge clk_i) begin
    filt_px_t e;
    m_axis_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        e = filtered_q.pop_front();
        if (m_axis_tdata[7:0] !== e.red || m_axis_tdata[15:8] !== e.green ||
            m_axis_tdata[23:16] !== e.blue || m_axis_tdata[34:24] !== e.col ||
            m_axis_tdata[45:35] !== e.row || m_axis_tlast !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp rgb %h %h %h col %0d row %0d last %b, got %h last %b",
                     e.red, e.green, e.blue, e.col, e.row, e.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 9;
    recv_idle_pct = 72;
    test_directed();
    test_backpressure();
    test_large_sizes();
    test_random(180, 9, 72);
    test_random(180, 72, 9);
    test_random(180, 0, 0);
    wait_idle();
    if (errors == 0) begin
      $display("tb_conv3x3_rgb_filter: PASS");
    end else begin
      $display("tb_conv3x3_rgb_filter: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hdl/c3f_pkg.sv
hdl/c3f_datapath.sv
hdl/c3f_ctrl.sv
hdl/conv3x3_rgb_filter.sv
verif/tb_conv3x3_rgb_filter.sv
